### rtl/lrc_pkg.sv
// Package for the LRU result cache: sizes, field widths and the match summary struct.
// Used by lrc_match and lru_result_cache_unit; depends on nothing else.
package lrc_pkg;

	// Cache geometry.
	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int AGE_W   = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Field widths of the request and response beats.
	localparam int KIND_W = 8;
	localparam int TAG_W  = 48;
	localparam int VAL_W  = 32;

	// Configuration register file.
	localparam int CAP_W    = 5;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Register index codes, taken from the word address bit.
	localparam logic REG_CAPACITY = 1'b0;

	// Request modes.
	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [AGE_W-1:0]  age_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// Summary of the parallel search over all entries.
	typedef struct packed {
		logic hit;       // a valid entry holds the key
		idx_t hit_idx;   // lowest entry that holds the key
		logic free_ok;   // some entry is not valid
		idx_t free_idx;  // lowest entry that is not valid
		idx_t old_idx;   // valid entry carrying the oldest rank
	} match_t;

endpackage

### rtl/lrc_match.sv
// Parallel key compare, free-entry search and oldest-entry search for the LRU cache.
// Depends on lrc_pkg for widths and the match_t struct.
module lrc_match
	import lrc_pkg::*;
(
	input  logic [ENTRIES-1:0] valid,
	input  kind_t              kind_arr [ENTRIES],
	input  tag_t               tag_arr  [ENTRIES],
	input  age_t               age_arr  [ENTRIES],
	input  kind_t              key_kind,
	input  tag_t               key_tag,
	input  age_t               oldest_age,
	output match_t             result
);

	// Every entry is compared at once; the loops walk downward so the lowest index wins.
	always_comb begin
		result = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid[i] && kind_arr[i] == key_kind && tag_arr[i] == key_tag) begin
				result.hit     = 1'b1;
				result.hit_idx = IDX_W'(i);
			end
			if (!valid[i]) begin
				result.free_ok  = 1'b1;
				result.free_idx = IDX_W'(i);
			end
			if (valid[i] && age_arr[i] == oldest_age) begin
				result.old_idx = IDX_W'(i);
			end
		end
	end

endmodule

### rtl/lru_result_cache_unit.sv
// Top level of the fully associative LRU result cache with its APB capacity register.
// Depends on lrc_pkg and instantiates lrc_match.
//
// A request beat is taken into an input register, searched against all entries at once
// and answered from a result register, so the cache accepts one lookup or insert per clock
// while the response side does not stall. A response is presented on the port from the
// result register and is taken while rsp_stall is low. The rate is set by the parallel
// compare of the key against every entry together with the recency update of all ranks.
// The valid marks and ranks clear at reset, so there is no clearing pass. The capacity
// register (byte address 0) may be written only while no request is in flight; a capacity
// of zero acts as one, and one above the entry count acts as the entry count. Lowering it
// below the current fill drops nothing: new keys then evict.
module lru_result_cache_unit
	import lrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              mode,
	input  kind_t             key_kind,
	input  tag_t              key_tag,
	input  val_t              value_in,
	// Response channel
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              hit,
	output val_t              value_out,
	output logic              evicted
);

	logic [CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]   eff_cap;

	logic               valid_s1;
	logic               mode_s1;
	kind_t              kind_s1;
	tag_t               tag_s1;
	val_t               val_s1;

	logic [ENTRIES-1:0] ent_valid_q;
	age_t               ent_age_q   [ENTRIES];
	kind_t              ent_kind_q  [ENTRIES];
	tag_t               ent_tag_q   [ENTRIES];
	val_t               ent_value_q [ENTRIES];
	logic [CNT_W-1:0]   fill_q;

	logic               rsp_valid_q;
	logic               hit_q;
	val_t               value_q;
	logic               evicted_q;

	match_t             m;
	age_t               oldest_age;
	logic               advance;
	logic               do_alloc;
	logic               do_evict;
	logic               do_touch;
	idx_t               sel_idx;
	age_t               sel_age;

	// Configuration register: written on the access phase, read back at any time.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = DATA_W'(cap_q);
		end
	end

	// Clamp the capacity into the range one to the entry count.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	// Handshake: the input stage moves on whenever the result register is free or draining.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			mode_s1 <= mode;
			kind_s1 <= key_kind;
			tag_s1  <= key_tag;
			val_s1  <= value_in;
		end
	end

	// The oldest valid entry always carries rank fill count minus one.
	assign oldest_age = AGE_W'(fill_q - CNT_W'(1));

	lrc_match u_match (
		.valid      (ent_valid_q),
		.kind_arr   (ent_kind_q),
		.tag_arr    (ent_tag_q),
		.age_arr    (ent_age_q),
		.key_kind   (kind_s1),
		.key_tag    (tag_s1),
		.oldest_age (oldest_age),
		.result     (m)
	);

	// Decide what this beat does to the entries.
	always_comb begin
		do_touch = m.hit;
		do_alloc = 1'b0;
		do_evict = 1'b0;
		sel_idx  = m.hit_idx;
		sel_age  = ent_age_q[m.hit_idx];
		if (mode_s1 == MODE_INSERT && !m.hit) begin
			if (fill_q < eff_cap && m.free_ok) begin
				do_alloc = 1'b1;
				sel_idx  = m.free_idx;
			end else begin
				do_evict = 1'b1;
				sel_idx  = m.old_idx;
				sel_age  = oldest_age;
			end
		end
	end

	// Recency ranks, valid marks and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			fill_q      <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				ent_age_q[i] <= '0;
			end
		end else if (valid_s1 && advance && (do_touch || do_alloc || do_evict)) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == sel_idx) begin
					ent_age_q[i] <= '0;
				end else if (ent_valid_q[i] && (do_alloc || ent_age_q[i] < sel_age)) begin
					ent_age_q[i] <= ent_age_q[i] + AGE_W'(1);
				end
			end
			if (do_alloc) begin
				ent_valid_q[sel_idx] <= 1'b1;
				fill_q               <= fill_q + CNT_W'(1);
			end
		end
	end

	// Key and value storage; written by inserts only.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance && mode_s1 == MODE_INSERT) begin
			ent_value_q[sel_idx] <= val_s1;
			if (!m.hit) begin
				ent_kind_q[sel_idx] <= kind_s1;
				ent_tag_q[sel_idx]  <= tag_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			hit_q     <= m.hit;
			evicted_q <= do_evict;
			if (mode_s1 == MODE_LOOKUP && m.hit) begin
				value_q <= ent_value_q[m.hit_idx];
			end else begin
				value_q <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign value_out = value_q;
	assign evicted   = evicted_q;

endmodule

### bench/tb_lru_result_cache_unit.sv
// Self-checking bench for lru_result_cache_unit: directed cases, then random lookups and inserts
// checked beat by beat against a recency-ranked cache model. Depends only on lrc_pkg and the RTL.
module tb_lru_result_cache_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import lrc_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 1500;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned MAX_WAIT       = 14;
	localparam int unsigned POOL_MAX       = 32;
	// Word index with no register behind it.
	localparam logic REG_UNUSED = 1'b1;

	typedef struct packed {
		logic hit;
		val_t value;
		logic evicted;
	} cache_result_t;

	// Model of the cache: entries with recency ranks, 0 being the most recent.
	class lru_cache_model;
		kind_t            slot_kind [ENTRIES];
		tag_t             slot_tag [ENTRIES];
		val_t             slot_value [ENTRIES];
		bit               slot_used [ENTRIES];
		int unsigned      slot_rank [ENTRIES];
		int unsigned      fill;
		logic [CAP_W-1:0] capacity;
		cache_result_t    pending_results[$];
		int unsigned      errors, lookups, inserts, hits, evictions, responses;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_rank[i] = 0;
			end
			fill = 0;
			capacity = CAP_RESET;
			errors = 0;
			lookups = 0;
			inserts = 0;
			hits = 0;
			evictions = 0;
			responses = 0;
		endfunction

		// A capacity of zero acts as one; anything above the entry count acts as the count.
		function int unsigned usable_slots();
			if (capacity == 0) return 1;
			if (capacity > ENTRIES) return ENTRIES;
			return capacity;
		endfunction

		// Move an entry to the front; every valid entry more recent than it ages by one.
		function void make_recent(int idx);
			int unsigned old_rank;
			old_rank = slot_rank[idx];
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && i != idx && slot_rank[i] < old_rank)
					slot_rank[i]++;
			slot_rank[idx] = 0;
		endfunction

		// Apply one accepted request beat and queue the response it must produce.
		function void note_request(logic m, kind_t k, tag_t t, val_t v);
			int            found;
			int            slot;
			int unsigned   oldest;
			cache_result_t r;
			found = -1;
			slot = -1;
			oldest = 0;
			r = '0;
			for (int i = 0; i < ENTRIES; i++)
				if (found < 0 && slot_used[i] && slot_kind[i] == k && slot_tag[i] == t)
					found = i;
			if (m == MODE_LOOKUP) begin
				lookups++;
				if (found >= 0) begin
					r.hit = 1'b1;
					r.value = slot_value[found];
					make_recent(found);
				end
			end else begin
				inserts++;
				if (found >= 0) begin
					// Present key: rewrite in place.
					r.hit = 1'b1;
					slot_value[found] = v;
					make_recent(found);
				end else begin
					if (fill < usable_slots()) begin
						for (int i = 0; i < ENTRIES; i++)
							if (slot < 0 && !slot_used[i])
								slot = i;
					end
					if (slot >= 0) begin
						for (int i = 0; i < ENTRIES; i++)
							if (slot_used[i])
								slot_rank[i]++;
						slot_used[slot] = 1'b1;
						slot_rank[slot] = 0;
						fill++;
					end else begin
						// No free entry within capacity: replace the least recent one.
						for (int i = 0; i < ENTRIES; i++)
							if (slot_used[i] && (slot < 0 || slot_rank[i] > oldest)) begin
								slot = i;
								oldest = slot_rank[i];
							end
						make_recent(slot);
						r.evicted = 1'b1;
					end
					slot_kind[slot] = k;
					slot_tag[slot] = t;
					slot_value[slot] = v;
				end
			end
			if (r.hit) hits++;
			if (r.evicted) evictions++;
			pending_results.push_back(r);
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH at %0t ns: %s", $realtime, msg);
		endtask

		// Compare one accepted response beat with the oldest queued response.
		task check_response(input logic h, input val_t v, input logic e);
			cache_result_t want;
			responses++;
			if (pending_results.size() == 0) begin
				report("response beat with no request outstanding");
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			if (h !== want.hit)
				report($sformatf("hit is %b, should be %b", h, want.hit));
			if (v !== want.value)
				report($sformatf("value_out is %h, should be %h", v, want.value));
			if (e !== want.evicted)
				report($sformatf("evicted is %b, should be %b", e, want.evicted));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              req_valid, req_stall;
	logic              mode;
	kind_t             key_kind;
	tag_t              key_tag;
	val_t              value_in;
	logic              rsp_valid, rsp_stall;
	logic              hit;
	val_t              value_out;
	logic              evicted;

	lru_cache_model model;
	bit             calm;
	int unsigned    idle_cycles;
	int unsigned    phase_caps [12] = '{16, 1, 3, 0, 8, 31, 2, 16, 17, 5, 1, 12};

	lru_result_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.mode      (mode),
		.key_kind  (key_kind),
		.key_tag   (key_tag),
		.value_in  (value_in),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.hit       (hit),
		.value_out (value_out),
		.evicted   (evicted)
	);

	always #5 clk = ~clk;

	// Wait drawn per beat; calm phases run both sides flat out.
	function automatic int unsigned pick_wait();
		if (calm) return 0;
		case ($urandom % 3)
			0: return 0;
			1: return $urandom_range(0, 3);
			default: return $urandom_range(0, MAX_WAIT);
		endcase
	endfunction

	// Monitor: feed the model, check responses and run the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (req_valid && !req_stall) begin
				model.note_request(mode, key_kind, key_tag, value_in);
				idle_cycles = 0;
			end
			if (rsp_valid && !rsp_stall) begin
				model.check_response(hit, value_out, evicted);
				idle_cycles = 0;
			end
			if (psel && penable && pready)
				idle_cycles = 0;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Response side: stall for a drawn number of cycles per beat.
	initial begin
		int unsigned hold;
		hold = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= 1'b0;
			end
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				hold = pick_wait();
		end
	end

	// Present one request beat after a drawn gap and hold it until taken. Starts and ends at a
	// falling edge.
	task automatic send_request(input logic m, input kind_t k, input tag_t t, input val_t v);
		int unsigned gap;
		gap = pick_wait();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode      <= m;
		key_kind  <= k;
		key_tag   <= t;
		value_in  <= v;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Stop sending and wait until every queued response has arrived.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (model.pending_results.size() != 0) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_register(input logic reg_index, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (reg_index == REG_CAPACITY)
			model.capacity = data[CAP_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// APB read of the capacity register, checked against the model.
	task automatic check_capacity();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {REG_CAPACITY, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[CAP_W-1:0] !== model.capacity)
			model.report($sformatf("capacity reads %0d, should be %0d",
				prdata[CAP_W-1:0], model.capacity));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Change the capacity while idle; upper data bits are noise the register must drop.
	task automatic set_capacity(input int unsigned cap);
		logic [DATA_W-1:0] data;
		data = $urandom;
		data[CAP_W-1:0] = cap[CAP_W-1:0];
		wait_drained();
		write_register(REG_CAPACITY, data);
		check_capacity();
	endtask

	initial begin
		kind_t       pool_kind [POOL_MAX];
		tag_t        pool_tag [POOL_MAX];
		int unsigned pool_size, per_phase, src;
		kind_t       k;
		tag_t        t;
		val_t        v;

		model       = new();
		calm        = 1'b0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		req_valid   = 1'b0;
		mode        = MODE_LOOKUP;
		key_kind    = '0;
		key_tag     = '0;
		value_in    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty miss, field extremes, hits, in-place update, near-miss keys.
		check_capacity();
		send_request(MODE_LOOKUP, '0, '0, '1);
		send_request(MODE_INSERT, '0, '0, '0);
		send_request(MODE_INSERT, '1, '1, '1);
		send_request(MODE_LOOKUP, '1, '1, '0);
		send_request(MODE_LOOKUP, '0, '0, '1);
		send_request(MODE_INSERT, '0, '0, 32'h5a5a_a5a5);
		send_request(MODE_LOOKUP, '0, '0, '0);
		send_request(MODE_LOOKUP, '0, tag_t'(1), '0);
		send_request(MODE_LOOKUP, kind_t'(1), '0, '0);
		send_request(MODE_INSERT, kind_t'(1), '0, val_t'(1));
		send_request(MODE_INSERT, '0, tag_t'(1), val_t'(2));

		// Capacity lowered below the fill: new keys evict, nothing is dropped.
		set_capacity(2);
		send_request(MODE_INSERT, kind_t'(2), tag_t'(2), val_t'(3));
		send_request(MODE_LOOKUP, '1, '1, '0);
		send_request(MODE_INSERT, kind_t'(3), tag_t'(3), val_t'(4));
		send_request(MODE_LOOKUP, '0, '0, '0);

		// Capacity zero acts as one.
		set_capacity(0);
		send_request(MODE_INSERT, kind_t'(4), tag_t'(4), val_t'(5));
		send_request(MODE_LOOKUP, kind_t'(4), tag_t'(4), '0);

		// Capacity above the entry count, then a write to an unmapped word.
		set_capacity(31);
		write_register(REG_UNUSED, '0);
		check_capacity();
		send_request(MODE_INSERT, kind_t'(5), tag_t'(5), val_t'(6));
		send_request(MODE_LOOKUP, kind_t'(3), tag_t'(3), '0);
		send_request(MODE_INSERT, kind_t'(4), tag_t'(4), '1);

		// Random phases, each with its own capacity and a key pool sized to force both
		// hits and evictions.
		per_phase = RANDOM_ITEMS / $size(phase_caps);
		foreach (phase_caps[p]) begin
			set_capacity(phase_caps[p]);
			calm = (p % 4 == 2);
			pool_size = model.usable_slots() + $urandom_range(1, 8);
			if (pool_size > POOL_MAX) pool_size = POOL_MAX;
			for (int i = 0; i < pool_size; i++) begin
				if (i > 0 && $urandom % 4 == 0) begin
					// Near neighbor of an earlier key: one bit apart.
					src = $urandom_range(0, i - 1);
					pool_kind[i] = pool_kind[src];
					pool_tag[i]  = pool_tag[src];
					if ($urandom % 2)
						pool_kind[i][$urandom % KIND_W] ^= 1'b1;
					else
						pool_tag[i][$urandom % TAG_W] ^= 1'b1;
				end else begin
					pool_kind[i] = kind_t'($urandom);
					pool_tag[i]  = tag_t'({$urandom, $urandom});
				end
			end
			for (int n = 0; n < per_phase; n++) begin
				if ($urandom % 100 < 85) begin
					src = $urandom_range(0, pool_size - 1);
					k = pool_kind[src];
					t = pool_tag[src];
				end else begin
					k = kind_t'($urandom);
					t = tag_t'({$urandom, $urandom});
				end
				case ($urandom % 16)
					0: v = '0;
					1: v = '1;
					default: v = $urandom;
				endcase
				send_request(logic'($urandom % 2), k, t, v);
				// Occasionally let the cache run completely dry.
				if ($urandom % 100 == 0)
					wait_drained();
			end
		end

		// Wind down: all responses in, then a few quiet cycles for stray beats.
		calm = 1'b0;
		wait_drained();
		repeat (4) @(negedge clk);
		if (model.pending_results.size() != 0)
			model.report($sformatf("%0d responses never arrived",
				model.pending_results.size()));
		$display("Ran %0d lookups and %0d inserts over %0d capacity settings plus directed cases.",
			model.lookups, model.inserts, $size(phase_caps));
		$display("Checked %0d responses: %0d hits, %0d evictions, %0d mismatches.",
			model.responses, model.hits, model.evictions, model.errors);
		if (model.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
